[src/flvp_pkg.sv]
package flvp_pkg;

    typedef struct packed {
        logic [7:0]  body_byte;
        logic [23:0] body_length;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic [3:0]  frame_kind;
        logic [3:0]  codec_code;
        logic [7:0]  packet_kind;
        logic [23:0] composition_offset;
        logic [7:0]  record_version;
        logic [7:0]  profile_code;
        logic [7:0]  compat_flags;
        logic [7:0]  level_code;
        logic [2:0]  prefix_size_found;
        logic [22:0] unit_count;
    } t_out_beat;

    typedef struct packed {
        logic [3:0] avc_codec_value;
        logic [3:0] hevc_codec_value;
        logic [2:0] nalu_prefix_bytes;
    } t_cfg;

    typedef enum logic [3:0] {
        PH_IDLE    = 4'd0,
        PH_PKT     = 4'd1,
        PH_COMP    = 4'd2,
        PH_REC     = 4'd3,
        PH_SETCNT  = 4'd4,
        PH_LENHI   = 4'd5,
        PH_LENLO   = 4'd6,
        PH_SKIP    = 4'd7,
        PH_NPREFIX = 4'd8,
        PH_NSKIP   = 4'd9,
        PH_DRAIN   = 4'd10
    } t_phase;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_LENSZ  = 3'd1;
    localparam logic [2:0] ST_NALU_LONG  = 3'd2;
    localparam logic [2:0] ST_PREFIX_UNK = 3'd3;
    localparam logic [2:0] ST_TRUNC      = 3'd4;

    localparam logic [1:0] CFG_AVC    = 2'd0;
    localparam logic [1:0] CFG_HEVC   = 2'd1;
    localparam logic [1:0] CFG_PREFIX = 2'd2;

    localparam logic [3:0] AVC_RESET    = 4'd7;
    localparam logic [3:0] HEVC_RESET   = 4'd12;
    localparam logic [2:0] PREFIX_RESET = 3'd4;

endpackage

[src/flvp_fifo.sv]
module flvp_fifo #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) r_wp <= !r_wp;
            if (w_rd) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_wr} - {1'b0, w_rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) r_mem[r_wp] <= i_data;
    end
endmodule

[src/flvp_parser.sv]
module flvp_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  flvp_pkg::t_cfg    i_cfg,
    input  logic              i_valid,
    input  flvp_pkg::t_in_beat i_beat,
    output logic              o_take,
    input  logic              i_out_full,
    output logic              o_push,
    output flvp_pkg::t_out_beat o_res
);
    localparam int WW = 26;

    flvp_pkg::t_phase r_phase, n_phase;
    logic [23:0] r_seen, n_seen, r_total, n_total, r_skip, n_skip;
    logic [7:0]  r_set, n_set;
    logic [31:0] r_pshift, n_pshift;
    logic [WW-1:0] r_walk, n_walk;
    logic [22:0] r_units, n_units;
    logic [7:0]  r_ver, n_ver, r_prof, n_prof, r_compat, n_compat, r_level, n_level;
    logic [2:0]  r_found, n_found, r_err, n_err, r_upl, n_upl;
    logic [3:0]  r_frame, n_frame, r_codec, n_codec;
    logic [7:0]  r_packet, n_packet;
    logic [23:0] r_comp, n_comp;
    logic [1:0]  r_stage, n_stage;
    logic        r_nalu, n_nalu;

    logic [7:0]  b;
    logic [23:0] pos, spare, len_m, v16, s24;
    logic [7:0]  s8, cnt;
    logic [31:0] ps;
    logic [2:0]  fnd;
    logic        w_final;

    assign b = i_beat.body_byte;
    assign len_m = i_beat.body_length
        & ((24'd1 << LENGTH_BITS) - 24'd1);

    always_comb begin
        n_phase = r_phase; n_seen = r_seen; n_total = r_total; n_skip = r_skip;
        n_set = r_set; n_pshift = r_pshift; n_walk = r_walk; n_units = r_units;
        n_ver = r_ver; n_prof = r_prof; n_compat = r_compat; n_level = r_level;
        n_found = r_found; n_err = r_err; n_upl = r_upl; n_frame = r_frame;
        n_codec = r_codec; n_packet = r_packet; n_comp = r_comp;
        n_stage = r_stage; n_nalu = r_nalu;
        pos = r_seen;
        spare = r_total - 24'd5;
        v16 = '0; s24 = '0; s8 = '0; cnt = '0; ps = '0; fnd = '0;
        case (r_phase)
            flvp_pkg::PH_IDLE: begin
                pos = '0;
                n_total = (len_m == 24'd0) ? 24'd1 : len_m;
                n_frame = b[7:4]; n_codec = b[3:0];
                n_packet = '0; n_comp = '0; n_ver = '0; n_prof = '0;
                n_compat = '0; n_level = '0; n_found = '0; n_units = '0;
                n_err = flvp_pkg::ST_OK; n_nalu = 1'b0; n_stage = '0;
                n_upl = '0; n_set = '0; n_skip = '0; n_pshift = '0; n_walk = '0;
                n_phase = (b[3:0] == i_cfg.avc_codec_value
                           || b[3:0] == i_cfg.hevc_codec_value)
                          ? flvp_pkg::PH_PKT : flvp_pkg::PH_DRAIN;
            end
            flvp_pkg::PH_PKT: begin
                n_packet = b;
                n_phase = flvp_pkg::PH_COMP;
            end
            flvp_pkg::PH_COMP: begin
                if (pos == 24'd2) n_comp[23:16] = b;
                if (pos == 24'd3) n_comp[15:8] = b;
                if (pos == 24'd4) begin
                    n_comp[7:0] = b;
                    if (r_packet == 8'd0) begin
                        n_phase = flvp_pkg::PH_REC;
                    end else if (r_packet == 8'd1) begin
                        n_nalu = 1'b1;
                        if (i_cfg.nalu_prefix_bytes != 3'd3
                            && i_cfg.nalu_prefix_bytes != 3'd4) begin
                            n_err = flvp_pkg::ST_PREFIX_UNK;
                            n_phase = flvp_pkg::PH_DRAIN;
                        end else begin
                            n_upl = i_cfg.nalu_prefix_bytes;
                            n_walk = '0;
                            if (spare > 24'd4) begin
                                n_phase = flvp_pkg::PH_NPREFIX;
                                n_set = {5'd0, i_cfg.nalu_prefix_bytes};
                                n_pshift = '0;
                            end else begin
                                n_phase = flvp_pkg::PH_DRAIN;
                            end
                        end
                    end else begin
                        n_phase = flvp_pkg::PH_DRAIN;
                    end
                end
            end
            flvp_pkg::PH_REC: begin
                if (pos == 24'd5) n_ver = b;
                else if (pos == 24'd6) n_prof = b;
                else if (pos == 24'd7) n_compat = b;
                else if (pos == 24'd8) n_level = b;
                else begin
                    fnd = {1'b0, b[1:0]} + 3'd1;
                    n_found = fnd;
                    if (fnd != 3'd3 && fnd != 3'd4) begin
                        n_err = flvp_pkg::ST_BAD_LENSZ;
                        n_phase = flvp_pkg::PH_DRAIN;
                    end else begin
                        n_stage = (r_codec == i_cfg.hevc_codec_value) ? 2'd0 : 2'd1;
                        n_phase = flvp_pkg::PH_SETCNT;
                    end
                end
            end
            flvp_pkg::PH_SETCNT: begin
                cnt = (r_stage < 2'd2) ? {3'd0, b[4:0]} : b;
                n_set = cnt;
                if (cnt != 8'd0) n_phase = flvp_pkg::PH_LENHI;
                else if (r_stage >= 2'd2) n_phase = flvp_pkg::PH_DRAIN;
                else begin
                    n_stage = r_stage + 2'd1;
                    n_phase = flvp_pkg::PH_SETCNT;
                end
            end
            flvp_pkg::PH_LENHI: begin
                n_skip = {8'd0, b, 8'd0};
                n_phase = flvp_pkg::PH_LENLO;
            end
            flvp_pkg::PH_LENLO, flvp_pkg::PH_SKIP: begin
                v16 = {8'd0, r_skip[15:8], b};
                s24 = (r_phase == flvp_pkg::PH_SKIP) ? r_skip - 24'd1 : v16;
                n_skip = s24;
                if (r_phase == flvp_pkg::PH_LENLO) n_phase = flvp_pkg::PH_SKIP;
                if (s24 == 24'd0) begin
                    // entry finished
                    s8 = r_set - 8'd1;
                    n_set = s8;
                    if (s8 != 8'd0) n_phase = flvp_pkg::PH_LENHI;
                    else if (r_stage >= 2'd2) n_phase = flvp_pkg::PH_DRAIN;
                    else begin
                        n_stage = r_stage + 2'd1;
                        n_phase = flvp_pkg::PH_SETCNT;
                    end
                end
            end
            flvp_pkg::PH_NPREFIX: begin
                ps = {r_pshift[23:0], b};
                s8 = r_set - 8'd1;
                n_pshift = ps;
                n_set = s8;
                if (s8 == 8'd0) begin
                    if (ps >= {8'd0, spare}) begin
                        n_err = flvp_pkg::ST_NALU_LONG;
                        n_phase = flvp_pkg::PH_DRAIN;
                    end else begin
                        n_units = r_units + 23'd1;
                        n_walk = r_walk + {2'd0, ps[23:0]} + {{(WW-3){1'b0}}, r_upl};
                        if (n_walk + 26'd4 < {2'd0, spare}) begin
                            if (ps == 32'd0) begin
                                n_phase = flvp_pkg::PH_NPREFIX;
                                n_set = {5'd0, r_upl};
                                n_pshift = '0;
                            end else begin
                                n_skip = ps[23:0];
                                n_phase = flvp_pkg::PH_NSKIP;
                            end
                        end else begin
                            n_phase = flvp_pkg::PH_DRAIN;
                        end
                    end
                end
            end
            flvp_pkg::PH_NSKIP: begin
                s24 = r_skip - 24'd1;
                n_skip = s24;
                if (s24 == 24'd0) begin
                    n_phase = flvp_pkg::PH_NPREFIX;
                    n_set = {5'd0, r_upl};
                    n_pshift = '0;
                end
            end
            default: ;
        endcase
        n_seen = pos + 24'd1;
    end

    assign w_final = (n_seen >= n_total);
    // only the final byte of a body needs room in the result queue
    assign o_take  = i_valid && !(i_out_full && w_final);
    assign o_push  = o_take && w_final;

    always_comb begin
        o_res.status = n_err;
        if (n_err == flvp_pkg::ST_OK && n_phase != flvp_pkg::PH_DRAIN
            && n_phase != flvp_pkg::PH_NSKIP && n_phase != flvp_pkg::PH_NPREFIX)
            o_res.status = flvp_pkg::ST_TRUNC;
        o_res.frame_kind         = n_frame;
        o_res.codec_code         = n_codec;
        o_res.packet_kind        = n_packet;
        o_res.composition_offset = n_comp;
        o_res.record_version     = n_ver;
        o_res.profile_code       = n_prof;
        o_res.compat_flags       = n_compat;
        o_res.level_code         = n_level;
        o_res.prefix_size_found  = n_found;
        o_res.unit_count         = n_nalu ? n_units : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= flvp_pkg::PH_IDLE;
        end else if (o_take) begin
            r_phase <= w_final ? flvp_pkg::PH_IDLE : n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_seen <= n_seen; r_total <= n_total; r_skip <= n_skip; r_set <= n_set;
            r_pshift <= n_pshift; r_walk <= n_walk; r_units <= n_units;
            r_ver <= n_ver; r_prof <= n_prof; r_compat <= n_compat;
            r_level <= n_level; r_found <= n_found; r_err <= n_err; r_upl <= n_upl;
            r_frame <= n_frame; r_codec <= n_codec; r_packet <= n_packet;
            r_comp <= n_comp; r_stage <= n_stage; r_nalu <= n_nalu;
        end
    end
endmodule

[src/flv_video_tag_body_parser.sv]
// One body byte per cycle, except a final byte waits while the result queue is full;
// the byte walk in the parser sets that sustained rate. The input queue registers
// each byte before the parser takes it; the final byte's take writes the result
// queue, which shows it the cycle after; non-final bytes flow while a result waits.
// Synchronous active-low reset empties both queues, idles the parser and
// restores the codec values 7 and 12 and prefix size 4.
module flv_video_tag_body_parser #(
    parameter int LENGTH_BITS = 24
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    output logic                full,
    input  flvp_pkg::t_in_beat  i_in_beat,
    output logic                empty,
    input  logic                pop,
    output flvp_pkg::t_out_beat o_out_beat,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [3:0]          i_cfg_data
);
    flvp_pkg::t_cfg      r_cfg;
    flvp_pkg::t_in_beat  w_beat;
    flvp_pkg::t_out_beat w_res;
    logic w_in_empty, w_take, w_push, w_out_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.avc_codec_value   <= flvp_pkg::AVC_RESET;
            r_cfg.hevc_codec_value  <= flvp_pkg::HEVC_RESET;
            r_cfg.nalu_prefix_bytes <= flvp_pkg::PREFIX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                flvp_pkg::CFG_AVC:    r_cfg.avc_codec_value   <= i_cfg_data;
                flvp_pkg::CFG_HEVC:   r_cfg.hevc_codec_value  <= i_cfg_data;
                flvp_pkg::CFG_PREFIX: r_cfg.nalu_prefix_bytes <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    flvp_fifo #(.WIDTH($bits(flvp_pkg::t_in_beat))) u_inq (
        .i_clk, .i_rst_n,
        .i_wr(push), .i_data(i_in_beat), .o_full(full),
        .i_rd(w_take), .o_data(w_beat), .o_empty(w_in_empty)
    );

    flvp_parser #(.LENGTH_BITS(LENGTH_BITS)) u_parser (
        .i_clk, .i_rst_n, .i_cfg(r_cfg),
        .i_valid(!w_in_empty), .i_beat(w_beat), .o_take(w_take),
        .i_out_full(w_out_full), .o_push(w_push), .o_res(w_res)
    );

    flvp_fifo #(.WIDTH($bits(flvp_pkg::t_out_beat))) u_outq (
        .i_clk, .i_rst_n,
        .i_wr(w_push), .i_data(w_res), .o_full(w_out_full),
        .i_rd(pop), .o_data(o_out_beat), .o_empty(empty)
    );
endmodule

[src/flvp_checker.sv]
module flvp_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                empty,
    input logic                pop,
    input flvp_pkg::t_out_beat o_out_beat
);
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_out_beat))
        else $error("result beat changed while stalled");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> o_out_beat.status <= flvp_pkg::ST_TRUNC)
        else $error("status code out of range");

    a_units_nalu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_beat.unit_count != '0 |-> o_out_beat.packet_kind == 8'd1)
        else $error("NALU count on a non-NALU packet");

    a_record_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_out_beat.prefix_size_found != '0 |-> o_out_beat.packet_kind == 8'd0)
        else $error("record bytes on a non-header packet");
endmodule

bind flv_video_tag_body_parser flvp_checker u_flvp_checker (
    .i_clk, .i_rst_n, .empty, .pop, .o_out_beat
);

[bench/tb_top.sv]
module tb_top;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 12;

    logic                i_clk;
    logic                i_rst_n;
    logic                push;
    logic                full;
    flvp_pkg::t_in_beat  i_in_beat;
    logic                empty;
    logic                pop;
    flvp_pkg::t_out_beat o_out_beat;
    logic                i_cfg_we;
    logic [1:0]          i_cfg_index;
    logic [3:0]          i_cfg_data;

    flv_video_tag_body_parser dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .push(push), .full(full), .i_in_beat(i_in_beat),
        .empty(empty), .pop(pop), .o_out_beat(o_out_beat),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    // stimulus and expected tag summaries
    flvp_pkg::t_in_beat  pending_beats[$];
    flvp_pkg::t_out_beat expected_tags[$];
    logic [7:0]          body_bytes[$];

    int unsigned cyc;
    int unsigned mismatches;
    int unsigned tags_checked;
    int unsigned bodies_sent;
    int unsigned hold_left;

    // shadow configuration
    logic [3:0] sh_avc;
    logic [3:0] sh_hevc;
    logic [2:0] sh_prefix;

    // shadow parser state
    flvp_pkg::t_phase ph;
    int unsigned seen, total, skip_left, sets_left, len_acc, walk_pos, units;
    logic [63:0] rec_bytes;
    int unsigned err_code, hd_frame, hd_codec, hd_pkt, hd_comp, arr_stage, pfx_len;
    bit          in_nalu;

    function automatic void clear_tag();
        ph = flvp_pkg::PH_IDLE;
        seen = 0; total = 0; skip_left = 0; sets_left = 0; len_acc = 0;
        walk_pos = 0; units = 0; rec_bytes = '0; err_code = 0;
        hd_frame = 0; hd_codec = 0; hd_pkt = 0; hd_comp = 0;
        arr_stage = 0; pfx_len = 0; in_nalu = 0;
    endfunction

    function automatic void abort_tag(int unsigned code);
        err_code = code;
        ph = flvp_pkg::PH_DRAIN;
    endfunction

    function automatic void next_param_array();
        if (arr_stage >= 2) begin
            ph = flvp_pkg::PH_DRAIN;
        end else begin
            arr_stage++;
            ph = flvp_pkg::PH_SETCNT;
        end
    endfunction

    function automatic void param_entry_done();
        sets_left = (sets_left - 1) & 8'hFF;
        if (sets_left == 0) next_param_array();
        else ph = flvp_pkg::PH_LENHI;
    endfunction

    function automatic void open_prefix();
        ph = flvp_pkg::PH_NPREFIX;
        sets_left = pfx_len;
        len_acc = 0;
    endfunction

    function automatic bit parse_tag_byte(input flvp_pkg::t_in_beat ib,
                                          output flvp_pkg::t_out_beat res);
        int unsigned b, pos, found, spare;
        b = ib.body_byte;
        res = '0;
        if (ph == flvp_pkg::PH_IDLE) begin
            clear_tag();
            total = ib.body_length;
            if (total == 0) total = 1;
            hd_frame = b >> 4;
            hd_codec = b & 4'hF;
            ph = (hd_codec == sh_avc || hd_codec == sh_hevc)
                 ? flvp_pkg::PH_PKT : flvp_pkg::PH_DRAIN;
            pos = 0;
        end else begin
            pos = seen;
            case (ph)
                flvp_pkg::PH_PKT: begin
                    hd_pkt = b;
                    ph = flvp_pkg::PH_COMP;
                end
                flvp_pkg::PH_COMP: begin
                    hd_comp |= b << (8 * ((4 - pos) & 3));
                    if (pos == 4) begin
                        if (hd_pkt == 0) begin
                            ph = flvp_pkg::PH_REC;
                        end else if (hd_pkt == 1) begin
                            in_nalu = 1;
                            if (sh_prefix != 3 && sh_prefix != 4) begin
                                abort_tag(flvp_pkg::ST_PREFIX_UNK);
                            end else begin
                                pfx_len = sh_prefix;
                                walk_pos = 0;
                                spare = total - 5;
                                if (4 < spare) open_prefix();
                                else ph = flvp_pkg::PH_DRAIN;
                            end
                        end else begin
                            ph = flvp_pkg::PH_DRAIN;
                        end
                    end
                end
                flvp_pkg::PH_REC: begin
                    if (pos < 9) begin
                        rec_bytes |= 64'(b) << (8 * ((pos - 5) & 7));
                    end else begin
                        found = (b & 3) + 1;
                        rec_bytes |= 64'(found) << 32;
                        if (found != 3 && found != 4) begin
                            abort_tag(flvp_pkg::ST_BAD_LENSZ);
                        end else begin
                            arr_stage = (hd_codec == sh_hevc) ? 0 : 1;
                            ph = flvp_pkg::PH_SETCNT;
                        end
                    end
                end
                flvp_pkg::PH_SETCNT: begin
                    sets_left = (arr_stage < 2) ? (b & 5'h1F) : b;
                    if (sets_left == 0) next_param_array();
                    else ph = flvp_pkg::PH_LENHI;
                end
                flvp_pkg::PH_LENHI: begin
                    skip_left = b << 8;
                    ph = flvp_pkg::PH_LENLO;
                end
                flvp_pkg::PH_LENLO: begin
                    skip_left |= b;
                    if (skip_left == 0) param_entry_done();
                    else ph = flvp_pkg::PH_SKIP;
                end
                flvp_pkg::PH_SKIP: begin
                    skip_left = (skip_left - 1) & 24'hFFFFFF;
                    if (skip_left == 0) param_entry_done();
                end
                flvp_pkg::PH_NPREFIX: begin
                    len_acc = (len_acc << 8) | b;
                    sets_left = (sets_left - 1) & 8'hFF;
                    if (sets_left == 0) begin
                        spare = total - 5;
                        if (len_acc >= spare) begin
                            abort_tag(flvp_pkg::ST_NALU_LONG);
                        end else begin
                            units = (units + 1) & 23'h7FFFFF;
                            walk_pos = walk_pos + len_acc + pfx_len;
                            if (walk_pos + 4 < spare) begin
                                if (len_acc == 0) begin
                                    open_prefix();
                                end else begin
                                    skip_left = len_acc;
                                    ph = flvp_pkg::PH_NSKIP;
                                end
                            end else begin
                                ph = flvp_pkg::PH_DRAIN;
                            end
                        end
                    end
                end
                flvp_pkg::PH_NSKIP: begin
                    skip_left = (skip_left - 1) & 24'hFFFFFF;
                    if (skip_left == 0) open_prefix();
                end
                default: ;
            endcase
        end

        seen = (seen + 1) & 24'hFFFFFF;
        if (seen < total) return 0;

        res.status = err_code[2:0];
        if (err_code == flvp_pkg::ST_OK && ph != flvp_pkg::PH_DRAIN
            && ph != flvp_pkg::PH_NSKIP && ph != flvp_pkg::PH_NPREFIX)
            res.status = flvp_pkg::ST_TRUNC;
        res.frame_kind         = hd_frame[3:0];
        res.codec_code         = hd_codec[3:0];
        res.packet_kind        = hd_pkt[7:0];
        res.composition_offset = hd_comp[23:0];
        res.record_version     = rec_bytes[7:0];
        res.profile_code       = rec_bytes[15:8];
        res.compat_flags       = rec_bytes[23:16];
        res.level_code         = rec_bytes[31:24];
        res.prefix_size_found  = rec_bytes[34:32];
        res.unit_count         = in_nalu ? units[22:0] : 23'd0;
        clear_tag();
        return 1;
    endfunction

    // ---------------- stimulus builders ----------------

    task automatic ship_body();
        flvp_pkg::t_in_beat bt;
        int                 n;
        n = body_bytes.size();
        for (int i = 0; i < n; i++) begin
            bt.body_byte   = body_bytes[i];
            bt.body_length = (i == 0) ? 24'(n) : 24'($urandom);
            if (i == 0 && n == 1 && $urandom_range(1) == 1) bt.body_length = '0;
            pending_beats.push_back(bt);
        end
        bodies_sent++;
        body_bytes.delete();
    endtask

    // cut short, pad or leave as is, then ship
    task automatic shape_and_ship();
        int mode;
        int keep;
        mode = $urandom_range(99);
        if (mode < 15 && body_bytes.size() > 1) begin
            keep = $urandom_range(body_bytes.size() - 1, 1);
            while (body_bytes.size() > keep) void'(body_bytes.pop_back());
        end else if (mode < 25) begin
            repeat ($urandom_range(4, 1)) body_bytes.push_back(8'($urandom));
        end
        ship_body();
    endtask

    function automatic logic [3:0] pick_video_codec();
        return ($urandom_range(1) == 1) ? sh_hevc : sh_avc;
    endfunction

    task automatic add_header(logic [3:0] codec, logic [7:0] pkt);
        body_bytes.push_back({4'($urandom_range(15)), codec});
        body_bytes.push_back(pkt);
        repeat (3) body_bytes.push_back(8'($urandom));
    endtask

    task automatic build_seq_header();
        logic [3:0] codec;
        int         first_stage, cnt, len;
        codec = pick_video_codec();
        first_stage = (codec == sh_hevc) ? 0 : 1;
        add_header(codec, 8'd0);
        repeat (4) body_bytes.push_back(8'($urandom));
        if ($urandom_range(99) < 85)
            body_bytes.push_back({6'($urandom), 2'($urandom_range(3, 2))});
        else
            body_bytes.push_back({6'($urandom), 2'($urandom_range(1))});
        for (int s = first_stage; s <= 2; s++) begin
            cnt = $urandom_range(2);
            if (s < 2) body_bytes.push_back({3'($urandom), 5'(cnt)});
            else body_bytes.push_back(8'(cnt));
            for (int e = 0; e < cnt; e++) begin
                len = $urandom_range(5);
                body_bytes.push_back(8'd0);
                body_bytes.push_back(8'(len));
                repeat (len) body_bytes.push_back(8'($urandom));
            end
        end
        shape_and_ship();
    endtask

    task automatic build_nalu_packet();
        int          psz;
        int unsigned v;
        psz = (sh_prefix == 3) ? 3 : 4;
        add_header(pick_video_codec(), 8'd1);
        for (int u = 0; u < $urandom_range(4); u++) begin
            if ($urandom_range(99) < 8) v = $urandom & 32'h00FF_FFFF;
            else v = $urandom_range(8);
            for (int k = psz - 1; k >= 0; k--) body_bytes.push_back(8'(v >> (8 * k)));
            if (v > 8) break;
            repeat (v) body_bytes.push_back(8'($urandom));
        end
        shape_and_ship();
    endtask

    task automatic build_noise(int max_len);
        repeat ($urandom_range(max_len, 1)) body_bytes.push_back(8'($urandom));
        ship_body();
    endtask

    task automatic build_random_mix(int n_bytes);
        int goal;
        int pick;
        goal = pending_beats.size() + n_bytes;
        while (pending_beats.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                build_nalu_packet();
            end else if (pick < 65) begin
                build_seq_header();
            end else if (pick < 80) begin
                build_noise(3);
            end else if (pick < 90) begin
                add_header(pick_video_codec(), 8'($urandom_range(255, 2)));
                shape_and_ship();
            end else begin
                build_noise(12);
            end
        end
    endtask

    task automatic build_directed();
        // one-byte bodies with length one or zero, other codec
        body_bytes.push_back(8'h00);
        ship_body();
        body_bytes.push_back(8'hFF);
        ship_body();
        // codec matches but body ends at once: truncated
        body_bytes.push_back({4'hA, sh_avc});
        ship_body();
        // unknown packet kind
        add_header(sh_hevc, 8'hFF);
        ship_body();
        // bad length size in the record
        add_header(sh_avc, 8'd0);
        body_bytes.push_back(8'hFF);
        body_bytes.push_back(8'h00);
        body_bytes.push_back(8'hAA);
        body_bytes.push_back(8'h55);
        body_bytes.push_back(8'hFC);
        ship_body();
        // nalu packet, one zero-length unit, then too little room for a next prefix
        add_header(sh_avc, 8'd1);
        repeat (4) body_bytes.push_back(8'h00);
        body_bytes.push_back(8'h07);
        ship_body();
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [3:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            flvp_pkg::CFG_AVC:    sh_avc    = val;
            flvp_pkg::CFG_HEVC:   sh_hevc   = val;
            flvp_pkg::CFG_PREFIX: sh_prefix = val[2:0];
            default: ;
        endcase
    endtask

    task automatic wait_quiet();
        while (pending_beats.size() != 0 || expected_tags.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ---------------- clock, reset, phases ----------------

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        logic [3:0] set_avc[7]  = '{4'd7, 4'd0, 4'd15, 4'd5, 4'd3, 4'd9, 4'd7};
        logic [3:0] set_hevc[7] = '{4'd12, 4'd15, 4'd0, 4'd5, 4'd9, 4'd3, 4'd12};
        logic [3:0] set_pfx[7]  = '{4'd4, 4'd3, 4'd4, 4'd3, 4'd0, 4'd2, 4'd1};
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = flvp_pkg::CFG_AVC;
        i_cfg_data  = '0;
        sh_avc      = flvp_pkg::AVC_RESET;
        sh_hevc     = flvp_pkg::HEVC_RESET;
        sh_prefix   = flvp_pkg::PREFIX_RESET;
        clear_tag();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        build_directed();
        build_random_mix(420);
        wait_quiet();
        for (int p = 1; p < 7; p++) begin
            write_cfg(flvp_pkg::CFG_AVC, set_avc[p]);
            write_cfg(flvp_pkg::CFG_HEVC, set_hevc[p]);
            write_cfg(flvp_pkg::CFG_PREFIX, set_pfx[p]);
            @(posedge i_clk);
            i_cfg_we <= 1'b0;
            @(posedge i_clk);
            build_random_mix(160);
            wait_quiet();
        end

        $display("Covered %0d tag bodies over 7 register settings; %0d summaries checked.",
                 bodies_sent, tags_checked);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatching summaries", mismatches);
            $display("FAILURE");
        end
        $finish;
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > LIMIT_CYCLES) begin
            $display("timeout at cycle %0d", cyc);
            $display("FAILURE");
            $finish;
        end
    end

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        flvp_pkg::t_out_beat want;
        bit                  calm;
        if (!i_rst_n) begin
            push      <= 1'b0;
            i_in_beat <= '0;
        end else begin
            if (push && !full) begin
                if (parse_tag_byte(i_in_beat, want)) expected_tags.push_back(want);
                void'(pending_beats.pop_front());
            end
            calm = (cyc >= 1500 && cyc < 2100);
            if (pending_beats.size() != 0 && (calm || $urandom_range(99) >= 20)) begin
                push      <= 1'b1;
                i_in_beat <= pending_beats[0];
            end else begin
                push <= 1'b0;
            end
        end
    end

    // ---------------- hold-off counter ----------------

    // long hold-off so both queues back up
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
        end else if (cyc == 300) begin
            hold_left <= 400;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        flvp_pkg::t_out_beat want;
        bit                  calm;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                tags_checked++;
                if (expected_tags.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected beat %p", o_out_beat);
                end else begin
                    want = expected_tags.pop_front();
                    if (o_out_beat !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: exp %p", want);
                            $display("          got %p", o_out_beat);
                        end
                    end
                end
            end
            calm = (cyc >= 1500 && cyc < 2100);
            if (cyc == 300 || hold_left != 0) begin
                pop <= 1'b0;
            end else begin
                pop <= calm || ($urandom_range(99) >= 20);
            end
        end
    end

endmodule
